// File: hw/rtl/pidsd_pkg.sv
package pidsd_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_GAIN_P = 2'd1;
    localparam logic [1:0] CFG_GAIN_I = 2'd2;
    localparam logic [1:0] CFG_GAIN_D = 2'd3;

    localparam logic signed [15:0] TARGET_RESET = 16'sd768;
    localparam logic [23:0]        GAIN_P_RESET = 24'd102400;
    localparam logic [23:0]        GAIN_I_RESET = 24'd0;
    localparam logic [23:0]        GAIN_D_RESET = 24'd0;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

    // drive limit and truncation toward zero
    localparam logic signed [43:0] DRIVE_LIMIT_WIDE = 44'sd2147483647;
    localparam logic signed [31:0] DRIVE_LIMIT      = 32'sd2147483647;
    localparam logic signed [58:0] TRUNC_BIAS       = 59'sd32767;

    // half-period mapping
    localparam logic [30:0] MAG_LOW    = 31'd150;
    localparam logic [30:0] MAG_HIGH   = 31'd10000;
    localparam logic [12:0] PERIOD_MIN = 13'd1400;
    localparam logic [12:0] PERIOD_MAX = 13'd5700;
    // 4300/9850 reduces to 86/197; ceil folded in as +196 before the floor divide
    localparam logic [19:0] STEP_NUM   = 20'd86;
    localparam logic [19:0] CEIL_BIAS  = 20'd196;
    // floor(n/197) = (n * ceil(2^28/197)) >> 28, exact for n < 2^20
    localparam logic [20:0] RECIP      = 21'd1362617;

    typedef struct packed {
        logic signed [16:0] err;
        logic signed [31:0] sum;
        logic signed [17:0] der;
    } t_err;

    typedef struct packed {
        logic signed [41:0] p;
        logic signed [56:0] i;
        logic signed [42:0] d;
    } t_prod;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               direction;
        logic               stepping;
        logic [12:0]        half_period_us;
    } t_res;

endpackage

// File: hw/rtl/pidsd_in_if.sv
interface pidsd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_angle;

    modport source (output valid, output measured_angle, input ready);
    modport sink   (input valid, input measured_angle, output ready);
endinterface

// File: hw/rtl/pidsd_out_if.sv
interface pidsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic               direction;
    logic               stepping;
    logic [12:0]        half_period_us;

    modport source (output valid, output drive, output direction, output stepping,
                    output half_period_us, input ready);
    modport sink   (input valid, input drive, input direction, input stepping,
                    input half_period_us, output ready);
endinterface

// File: hw/rtl/pid_step_delay_controller.sv
// Six-stage pipeline: error/integral, gain products, sum, drive, period prep, output.
// Each input passes through every stage register in turn before its result is valid at the output.
// Throughput: one item per cycle while the output is not held; each stage advances independently,
// so bubbles are squeezed out and input transfers continue while the output is held, until all six
// stages are full. Reset (synchronous, active low): pipeline emptied, integral and
// last error cleared, target 768, gain_p 102400, gain_i and gain_d zero.
module pid_step_delay_controller import pidsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    pidsd_in_if.sink    i_in,
    pidsd_out_if.source o_out
);

    logic signed [15:0] r_target;
    logic [23:0]        r_gain_p;
    logic [23:0]        r_gain_i;
    logic [23:0]        r_gain_d;

    logic               w_f_valid;
    logic               w_f_ready;
    t_prod              w_prod;
    logic               w_l_valid;
    logic               w_l_ready;
    logic signed [31:0] w_drive;
    t_res               w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_gain_p <= GAIN_P_RESET;
            r_gain_i <= GAIN_I_RESET;
            r_gain_d <= GAIN_D_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET: r_target <= $signed(i_cfg_data[15:0]);
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                default:    r_target <= r_target;
            endcase
        end
    end

    pidsd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in.valid),
        .o_ready          (i_in.ready),
        .i_measured_angle (i_in.measured_angle),
        .i_target_angle   (r_target),
        .i_gain_p         (r_gain_p),
        .i_gain_i         (r_gain_i),
        .i_gain_d         (r_gain_d),
        .o_valid          (w_f_valid),
        .i_ready          (w_f_ready),
        .o_prod           (w_prod)
    );

    pidsd_law u_law (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_prod  (w_prod),
        .o_valid (w_l_valid),
        .i_ready (w_l_ready),
        .o_drive (w_drive)
    );

    pidsd_period u_period (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_l_valid),
        .o_ready (w_l_ready),
        .i_drive (w_drive),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (w_res)
    );

    assign o_out.drive          = w_res.drive;
    assign o_out.direction      = w_res.direction;
    assign o_out.stepping       = w_res.stepping;
    assign o_out.half_period_us = w_res.half_period_us;

    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_dir_needs_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.direction |-> o_out.stepping && !o_out.drive[31])
        else $error("direction set without positive drive");

    a_idle_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.stepping |-> o_out.half_period_us == PERIOD_MAX)
        else $error("half-period not at maximum for zero drive");

    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.half_period_us >= PERIOD_MIN
                     && o_out.half_period_us <= PERIOD_MAX)
        else $error("half-period out of range");

endmodule

// File: hw/rtl/pidsd_front.sv
module pidsd_front import pidsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_measured_angle,
    input  logic signed [15:0] i_target_angle,
    input  logic [23:0]        i_gain_p,
    input  logic [23:0]        i_gain_i,
    input  logic [23:0]        i_gain_d,
    output logic               o_valid,
    input  logic               i_ready,
    output t_prod              o_prod
);

    logic               r_va;
    logic               r_vb;
    t_err               r_err;
    t_prod              r_prod;
    logic signed [31:0] r_error_sum;
    logic signed [16:0] r_prior_error;

    logic               w_adv_a;
    logic               w_adv_b;
    logic               w_take;
    logic signed [16:0] w_err;
    logic signed [32:0] w_sum_wide;
    logic signed [31:0] w_sum;
    logic signed [17:0] w_der;
    t_prod              n_prod;

    assign w_adv_b = !r_vb || i_ready;
    assign w_adv_a = !r_va || w_adv_b;
    assign w_take  = i_valid && w_adv_a;
    assign o_ready = w_adv_a;

    assign w_err      = $signed({i_target_angle[15], i_target_angle})
                      - $signed({i_measured_angle[15], i_measured_angle});
    assign w_sum_wide = $signed({r_error_sum[31], r_error_sum})
                      + $signed({{16{w_err[16]}}, w_err});
    assign w_der      = $signed({w_err[16], w_err})
                      - $signed({r_prior_error[16], r_prior_error});

    // integral saturates instead of wrapping
    always_comb begin
        if (w_sum_wide[32] != w_sum_wide[31]) begin
            w_sum = w_sum_wide[32] ? INT32_MIN : INT32_MAX;
        end else begin
            w_sum = w_sum_wide[31:0];
        end
    end

    always_comb begin
        n_prod.p = $signed({1'b0, i_gain_p}) * r_err.err;
        n_prod.i = $signed({1'b0, i_gain_i}) * r_err.sum;
        n_prod.d = $signed({1'b0, i_gain_d}) * r_err.der;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va          <= 1'b0;
            r_vb          <= 1'b0;
            r_error_sum   <= '0;
            r_prior_error <= '0;
        end else begin
            if (w_adv_a) begin
                r_va <= i_valid;
            end
            if (w_adv_b) begin
                r_vb <= r_va;
            end
            if (w_take) begin
                r_error_sum   <= w_sum;
                r_prior_error <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_err.err <= w_err;
            r_err.sum <= w_sum;
            r_err.der <= w_der;
        end
        if (w_adv_b && r_va) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_vb;
    assign o_prod  = r_prod;

endmodule

// File: hw/rtl/pidsd_law.sv
module pidsd_law import pidsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_prod              i_prod,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_drive
);

    logic               r_vc;
    logic               r_vd;
    logic signed [58:0] r_raw;
    logic signed [31:0] r_drive;

    logic               w_adv_c;
    logic               w_adv_d;
    logic signed [58:0] w_raw;
    logic signed [58:0] w_bias;
    logic signed [43:0] w_q;
    logic signed [31:0] n_drive;

    assign w_adv_d = !r_vd || i_ready;
    assign w_adv_c = !r_vc || w_adv_d;
    assign o_ready = w_adv_c;

    assign w_raw = $signed({{17{i_prod.p[41]}}, i_prod.p})
                 + $signed({{2{i_prod.i[56]}}, i_prod.i})
                 + $signed({{16{i_prod.d[42]}}, i_prod.d});

    // bias negatives so the arithmetic shift truncates toward zero
    assign w_bias = r_raw + (r_raw[58] ? TRUNC_BIAS : 59'sd0);
    assign w_q    = w_bias[58:15];

    always_comb begin
        if (w_q > DRIVE_LIMIT_WIDE) begin
            n_drive = DRIVE_LIMIT;
        end else if (w_q < -DRIVE_LIMIT_WIDE) begin
            n_drive = -DRIVE_LIMIT;
        end else begin
            n_drive = w_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (w_adv_c) begin
                r_vc <= i_valid;
            end
            if (w_adv_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c && i_valid) begin
            r_raw <= w_raw;
        end
        if (w_adv_d && r_vc) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_vd;
    assign o_drive = r_drive;

endmodule

// File: hw/rtl/pidsd_period.sv
module pidsd_period import pidsd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_drive,
    output logic               o_valid,
    input  logic               i_ready,
    output t_res               o_res
);

    logic               r_ve;
    logic               r_vf;
    logic signed [31:0] r_drive;
    logic               r_low;
    logic               r_high;
    logic [19:0]        r_n2;
    t_res               r_res;

    logic               w_adv_e;
    logic               w_adv_f;
    logic [31:0]        w_neg;
    logic [30:0]        w_mag;
    logic [30:0]        w_diff;
    logic [19:0]        w_n2;
    logic [40:0]        w_scaled;
    logic [12:0]        w_dec;
    t_res               n_res;

    assign w_adv_f = !r_vf || i_ready;
    assign w_adv_e = !r_ve || w_adv_f;
    assign o_ready = w_adv_e;

    // |drive| never exceeds 2^31-1 since the drive is clamped symmetrically
    assign w_neg  = -i_drive;
    assign w_mag  = i_drive[31] ? w_neg[30:0] : i_drive[30:0];
    assign w_diff = w_mag - MAG_LOW;
    assign w_n2   = {6'd0, w_diff[13:0]} * STEP_NUM + CEIL_BIAS;

    assign w_scaled = {21'd0, r_n2} * {20'd0, RECIP};
    assign w_dec    = w_scaled[40:28];

    always_comb begin
        n_res.drive     = r_drive;
        n_res.direction = !r_drive[31] && (r_drive != 32'sd0);
        n_res.stepping  = (r_drive != 32'sd0);
        priority if (r_low) begin
            n_res.half_period_us = PERIOD_MAX;
        end else if (r_high) begin
            n_res.half_period_us = PERIOD_MIN;
        end else begin
            n_res.half_period_us = PERIOD_MAX - w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else begin
            if (w_adv_e) begin
                r_ve <= i_valid;
            end
            if (w_adv_f) begin
                r_vf <= r_ve;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_e && i_valid) begin
            r_drive <= i_drive;
            r_low   <= (w_mag < MAG_LOW);
            r_high  <= (w_mag > MAG_HIGH);
            r_n2    <= w_n2;
        end
        if (w_adv_f && r_ve) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_vf;
    assign o_res   = r_res;

endmodule
